// ----- design/tsq_pkg.sv -----
// Package: shared widths and constants for the thick segment to quad unit.
`default_nettype none
package tsq_pkg;
  localparam int HW_W   = 15;          // half width register
  localparam int RED_W  = 15;          // reduced delta magnitude width
  localparam int PRD_W  = 2 * RED_W;   // one product of two reduced values
  localparam int L_W    = PRD_W + 1;   // squared length
  localparam int R_W    = 2 * PRD_W + 2; // 4*(h*c)^2
  localparam int N_W    = 16;          // root digits
  localparam int NL_W   = L_W + N_W;   // root times length
  localparam int T_W    = 64;          // trial width
  localparam int Q_W    = N_W;         // offset magnitude
  localparam logic [HW_W-1:0] HW_RESET = HW_W'(16);
endpackage
`default_nettype wire

// ----- design/thick_segment_to_quad_unit.sv -----
// Top level: pipelined thick line segment to quad corner unit.
`default_nettype none
// One segment beat is taken every clock (busy is always low). Its four
// corners are driven from the output register, with out_valid high
// for one cycle.
// Each beat passes through delta, reduction, multiply and length stages,
// then a 16-stage digit-serial root/divide pipeline (one result bit per
// stage), then the output register.
// half_width must only be written while no segment is in flight.
module thick_segment_to_quad_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_y,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tsq_pkg::HW_W-1:0]      cfg_wr_data,
  output logic                               out_valid,
  output logic signed [COORD_WIDTH-1:0]      out_corner_a_x,
  output logic signed [COORD_WIDTH-1:0]      out_corner_a_y,
  output logic signed [COORD_WIDTH-1:0]      out_corner_b_x,
  output logic signed [COORD_WIDTH-1:0]      out_corner_b_y,
  output logic signed [COORD_WIDTH-1:0]      out_corner_c_x,
  output logic signed [COORD_WIDTH-1:0]      out_corner_c_y,
  output logic signed [COORD_WIDTH-1:0]      out_corner_d_x,
  output logic signed [COORD_WIDTH-1:0]      out_corner_d_y,
  output logic                               out_zero_length
);
  import tsq_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int EW   = (DW > RED_W) ? DW : RED_W;
  localparam int SW   = ((CW > Q_W + 1) ? CW : Q_W + 1) + 2;
  localparam int NSQ  = N_W;
  localparam int LINE = 4 + NSQ;

  // configuration register
  logic [HW_W-1:0] hw_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= HW_RESET;
    end else if (cfg_wr_en) begin
      hw_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // coordinate and valid lines that run beside the math
  logic [4*CW-1:0] crd_r [0:LINE-1];
  logic            vld_r [0:LINE-1];
  logic [1:0]      flg_r [1:LINE-1];   // {zero, negx}

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LINE; j++) vld_r[j] <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int j = 1; j < LINE; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    crd_r[0] <= {in_start_x, in_start_y, in_end_x, in_end_y};
    for (int j = 1; j < LINE; j++) crd_r[j] <= crd_r[j-1];
  end

  // stage 1: deltas
  logic signed [DW-1:0] dx_r, dy_r;
  always_ff @(posedge clk) begin
    dx_r <= {in_end_x[CW-1], in_end_x} - {in_start_x[CW-1], in_start_x};
    dy_r <= {in_end_y[CW-1], in_end_y} - {in_start_y[CW-1], in_start_y};
  end

  // stage 2: magnitudes, signs and joint reduction below 2^15
  logic [DW-1:0]    mag_a, mag_b;
  logic [EW-1:0]    ext_a, ext_b, ext_m;
  logic [RED_W-1:0] a_nxt, b_nxt, a_r, b_r;
  int               hb, sh;
  always_comb begin
    mag_a = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
    mag_b = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
    ext_a = EW'(mag_a);
    ext_b = EW'(mag_b);
    ext_m = ext_a | ext_b;
    hb = 0;
    for (int i = 0; i < EW; i++) begin
      if (ext_m[i]) hb = i;
    end
    sh = (hb >= RED_W) ? hb - (RED_W - 1) : 0;
    a_nxt = RED_W'(ext_a >> sh);
    b_nxt = RED_W'(ext_b >> sh);
  end

  // flags enter here and advance beside the coordinates
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    flg_r[1] <= {(dx_r == '0) && (dy_r == '0),
                 (dx_r[DW-1] != dy_r[DW-1]) && (dy_r != '0)};
    for (int j = 2; j < LINE; j++) flg_r[j] <= flg_r[j-1];
  end

  // stage 3: squares and scaled components
  logic [PRD_W-1:0] asq_r, bsq_r, hbx_r, hay_r;
  always_ff @(posedge clk) begin
    asq_r <= a_r * a_r;
    bsq_r <= b_r * b_r;
    hbx_r <= hw_r * b_r;
    hay_r <= hw_r * a_r;
  end

  // stage 4 onward: root pipeline state, index 0 is the setup stage
  logic [L_W-1:0]  len_r [0:NSQ];
  logic [R_W-1:0]  dxr_r [0:NSQ];
  logic [R_W-1:0]  dyr_r [0:NSQ];
  logic [NL_W-1:0] nlx_r [0:NSQ];
  logic [NL_W-1:0] nly_r [0:NSQ];
  logic [N_W-1:0]  nx_r  [0:NSQ];
  logic [N_W-1:0]  ny_r  [0:NSQ];

  // setup: length squared and 4*(h*c)^2
  always_ff @(posedge clk) begin
    len_r[0] <= L_W'(asq_r) + L_W'(bsq_r);
    dxr_r[0] <= {(2*PRD_W)'(hbx_r) * (2*PRD_W)'(hbx_r), 2'b00};
    dyr_r[0] <= {(2*PRD_W)'(hay_r) * (2*PRD_W)'(hay_r), 2'b00};
    nlx_r[0] <= '0;
    nly_r[0] <= '0;
    nx_r[0]  <= '0;
    ny_r[0]  <= '0;
  end

  // one root bit per stage: largest n with n^2*L <= R
  for (genvar i = 0; i < NSQ; i++) begin : g_root
    localparam int K = NSQ - 1 - i;
    logic [T_W-1:0] tx, ty, lsq;
    logic [NL_W-1:0] lk;
    always_comb begin
      lsq = T_W'(len_r[i]) << (2 * K);
      lk  = NL_W'(len_r[i]) << K;
      tx  = (T_W'(nlx_r[i]) << (K + 1)) + lsq;
      ty  = (T_W'(nly_r[i]) << (K + 1)) + lsq;
    end
    always_ff @(posedge clk) begin
      len_r[i+1] <= len_r[i];
      if (tx <= T_W'(dxr_r[i])) begin
        dxr_r[i+1] <= dxr_r[i] - R_W'(tx);
        nlx_r[i+1] <= nlx_r[i] + lk;
        nx_r[i+1]  <= nx_r[i] | (N_W'(1) << K);
      end else begin
        dxr_r[i+1] <= dxr_r[i];
        nlx_r[i+1] <= nlx_r[i];
        nx_r[i+1]  <= nx_r[i];
      end
      if (ty <= T_W'(dyr_r[i])) begin
        dyr_r[i+1] <= dyr_r[i] - R_W'(ty);
        nly_r[i+1] <= nly_r[i] + lk;
        ny_r[i+1]  <= ny_r[i] | (N_W'(1) << K);
      end else begin
        dyr_r[i+1] <= dyr_r[i];
        nly_r[i+1] <= nly_r[i];
        ny_r[i+1]  <= ny_r[i];
      end
    end
  end

  // saturate a wide sum to the coordinate range
  function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    begin
      hi = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
      lo = -hi - SW'(1);
      if (v > hi) sat = CW'(hi);
      else if (v < lo) sat = CW'(lo);
      else sat = CW'(v);
    end
  endfunction

  // final: round to offsets, apply signs, form corners
  logic [4*CW-1:0]        crd;
  logic [1:0]             flg;
  logic [N_W:0]           qx_w, qy_w;
  logic signed [SW-1:0]   offx, offy, sxw, syw, exw, eyw;
  always_comb begin
    crd  = crd_r[LINE-1];
    flg  = flg_r[LINE-1];
    qx_w = ({1'b0, nx_r[NSQ]} + (N_W+1)'(1)) >> 1;
    qy_w = ({1'b0, ny_r[NSQ]} + (N_W+1)'(1)) >> 1;
    offx = flg[1] ? '0 : SW'(qx_w);
    offy = flg[1] ? '0 : SW'(qy_w);
    if (flg[0]) offx = -offx;
    sxw = SW'($signed(crd[4*CW-1:3*CW]));
    syw = SW'($signed(crd[3*CW-1:2*CW]));
    exw = SW'($signed(crd[2*CW-1:CW]));
    eyw = SW'($signed(crd[CW-1:0]));
  end

  // output register: one beat per cycle
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[LINE-1];
    end
  end

  always_ff @(posedge clk) begin
    out_corner_a_x  <= sat(sxw + offx);
    out_corner_a_y  <= sat(syw - offy);
    out_corner_b_x  <= sat(sxw - offx);
    out_corner_b_y  <= sat(syw + offy);
    out_corner_c_x  <= sat(exw - offx);
    out_corner_c_y  <= sat(eyw + offy);
    out_corner_d_x  <= sat(exw + offx);
    out_corner_d_y  <= sat(eyw - offy);
    out_zero_length <= flg[1];
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire
